/* rtl/core/wifi_ie_parser_top_defines.svh */
// Assertion macros for the information element parser.
`ifndef WIFI_IE_PARSER_TOP_DEFINES_SVH
`define WIFI_IE_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define WIP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wip assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define WIP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wip assertion failed");
`else
`define WIP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define WIP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/core/wip_pkg.sv */
// Types, constants and the rate table of the information element parser.
package wip_pkg;

    localparam int SSID_MAX   = 32;
    localparam int SSID_CNT_W = 6;

    localparam logic [7:0] ELEM_ID_SSID  = 8'd0;
    localparam logic [7:0] ELEM_ID_RATES = 8'd1;
    localparam logic [7:0] ELEM_ID_RSN   = 8'd48;
    localparam logic [7:0] RSN_LEN_MIN   = 8'd14;
    localparam logic [1:0] SEL_LAST      = 2'd3;   // last octet of a 4-octet selector

    // parse phases
    localparam logic [3:0] PH_TYPE  = 4'd0;
    localparam logic [3:0] PH_LEN   = 4'd1;
    localparam logic [3:0] PH_SSID  = 4'd2;
    localparam logic [3:0] PH_RATES = 4'd3;
    localparam logic [3:0] PH_SKIP  = 4'd4;
    localparam logic [3:0] PH_VER   = 4'd5;
    localparam logic [3:0] PH_GROUP = 4'd6;
    localparam logic [3:0] PH_PCNT  = 4'd7;
    localparam logic [3:0] PH_PAIR  = 4'd8;
    localparam logic [3:0] PH_ACNT  = 4'd9;
    localparam logic [3:0] PH_AKM   = 4'd10;

    // result kinds
    localparam logic [2:0] KIND_SSID  = 3'd0;
    localparam logic [2:0] KIND_RATE  = 3'd1;
    localparam logic [2:0] KIND_GROUP = 3'd2;
    localparam logic [2:0] KIND_PAIR  = 3'd3;
    localparam logic [2:0] KIND_AKM   = 3'd4;
    localparam logic [2:0] KIND_DONE  = 3'd5;
    localparam logic [2:0] KIND_ERROR = 3'd6;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  ssid_byte;
        logic [5:0]  rate_whole;
        logic [3:0]  rate_tenths;
        logic        basic_rate;
        logic [31:0] suite_word;
        logic        end_of_run;
    } t_result;

    typedef struct packed {
        logic [5:0] whole;
        logic [3:0] tenths;
    } t_rate;

    function automatic t_rate rate_lookup(input logic [6:0] code);
        t_rate r;
        r.tenths = 4'd0;
        case (code)
            7'd2:    r.whole = 6'd1;
            7'd4:    r.whole = 6'd2;
            7'd11: begin
                r.whole  = 6'd5;
                r.tenths = 4'd5;
            end
            7'd12:   r.whole = 6'd6;
            7'd18:   r.whole = 6'd9;
            7'd22:   r.whole = 6'd11;
            7'd24:   r.whole = 6'd12;
            7'd36:   r.whole = 6'd18;
            7'd44:   r.whole = 6'd22;
            7'd48:   r.whole = 6'd24;
            7'd66:   r.whole = 6'd33;
            7'd72:   r.whole = 6'd36;
            7'd96:   r.whole = 6'd48;
            7'd108:  r.whole = 6'd54;
            default: r.whole = 6'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/wip_if.sv */
// Valid/ready stream interfaces for the parser's byte input and result output.
interface wip_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [15:0] bytes_left;

    modport source (output valid, output data_byte, output bytes_left, input ready);
    modport sink   (input valid, input data_byte, input bytes_left, output ready);
endinterface

interface wip_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  ssid_byte;
    logic [5:0]  rate_whole;
    logic [3:0]  rate_tenths;
    logic        basic_rate;
    logic [31:0] suite_word;
    logic        end_of_run;

    modport source (output valid, output kind, output ssid_byte, output rate_whole,
                    output rate_tenths, output basic_rate, output suite_word,
                    output end_of_run, input ready);
    modport sink   (input valid, input kind, input ssid_byte, input rate_whole,
                    input rate_tenths, input basic_rate, input suite_word,
                    input end_of_run, output ready);
endinterface

/* rtl/core/wifi_ie_parser_top.sv */
// Top level of the 802.11 information element parser.
//
// Takes one buffer byte per transaction on i_in, with the count of bytes that
// follow it (zero marks the last byte of the frame), walks the type-length-value
// headers and posts results on o_out: SSID octets (at most SSID_MAX per element),
// decoded supported rates, RSN group/pairwise/AKM suites, an error on a bad RSN
// length or count, and a done result closing every frame, after which the parser
// is back in its reset state. A byte is taken every cycle while i_in.ready is high: each
// accepted byte is decoded in the same cycle into at most two results, which land in
// a 4-entry result queue; results leave one per cycle while o_out.ready is high, so a
// last byte may queue both its result and the done. i_in.ready is high while the queue
// holds two or fewer results. Results are registered in the queue.
// There is no clearing pass; the parser is usable straight after reset.
module wifi_ie_parser_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wip_in_if.sink    i_in,
    wip_out_if.source o_out
);
    import wip_pkg::*;

    `include "wifi_ie_parser_top_defines.svh"

    // parser state
    logic [3:0]            r_phase, n_phase;
    logic [7:0]            r_type, n_type;
    logic [7:0]            r_el, n_el;           // octets left in element
    logic [1:0]            r_pos, n_pos;         // octet position in RSN field
    logic [15:0]           r_suites, n_suites;
    logic [7:0]            r_cnt_lo, n_cnt_lo;
    logic [31:0]           r_shift, n_shift;
    logic [SSID_CNT_W-1:0] r_ssid, n_ssid;
    logic                  r_stopped, n_stopped;

    // result queue
    t_result    r_fifo [4];
    logic [1:0] r_wr_ptr, r_rd_ptr;
    logic [2:0] r_count;

    logic       acc, pop;
    logic [7:0] b;
    logic [15:0] left;
    logic [7:0] el_dec;
    logic [15:0] cnt;
    logic [31:0] shift_new;
    logic       a_vld, done, body_fail, is_body;
    t_result    a_res, done_res, res0, res1;
    t_rate      rate;
    logic [2:0] n_push;

    assign acc  = i_in.valid && i_in.ready;
    assign pop  = o_out.valid && o_out.ready;
    assign b    = i_in.data_byte;
    assign left = i_in.bytes_left;
    assign el_dec    = r_el - 8'd1;
    assign cnt       = {b, r_cnt_lo};
    assign shift_new = {r_shift[23:0], b};
    assign rate      = rate_lookup(b[6:0]);
    assign is_body   = (r_phase >= PH_SSID) && (r_phase <= PH_AKM);

    always_comb begin
        n_phase   = r_phase;
        n_type    = r_type;
        n_el      = r_el;
        n_pos     = r_pos;
        n_suites  = r_suites;
        n_cnt_lo  = r_cnt_lo;
        n_shift   = r_shift;
        n_ssid    = r_ssid;
        n_stopped = r_stopped;
        a_vld     = 1'b0;
        a_res     = '0;
        done      = 1'b0;
        body_fail = 1'b0;

        if (acc) begin
            if (!r_stopped) begin
                if (is_body) begin
                    n_el = el_dec;
                end
                case (r_phase)
                    PH_TYPE: begin
                        n_type = b;
                        if (left == 16'd0) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        n_el = b;
                        if ({8'd0, b} > left) begin
                            n_stopped = 1'b1;
                        end else if (r_type == ELEM_ID_RSN && b < RSN_LEN_MIN) begin
                            a_vld      = 1'b1;
                            a_res.kind = KIND_ERROR;
                            n_stopped  = 1'b1;
                        end else begin
                            n_ssid  = '0;
                            n_pos   = 2'd0;
                            n_shift = 32'd0;
                            if (b == 8'd0) begin
                                n_phase = PH_TYPE;
                            end else if (r_type == ELEM_ID_SSID) begin
                                n_phase = PH_SSID;
                            end else if (r_type == ELEM_ID_RATES) begin
                                n_phase = PH_RATES;
                            end else if (r_type == ELEM_ID_RSN) begin
                                n_phase = PH_VER;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                    PH_SSID: begin
                        if (r_ssid < SSID_CNT_W'(SSID_MAX)) begin
                            a_vld           = 1'b1;
                            a_res.kind      = KIND_SSID;
                            a_res.ssid_byte = b;
                            n_ssid          = r_ssid + 1'b1;
                        end
                    end
                    PH_RATES: begin
                        a_vld             = 1'b1;
                        a_res.kind        = KIND_RATE;
                        a_res.rate_whole  = rate.whole;
                        a_res.rate_tenths = rate.tenths;
                        a_res.basic_rate  = b[7];
                    end
                    PH_SKIP: begin
                    end
                    PH_VER: begin
                        if (r_pos == 2'd1) begin
                            n_pos   = 2'd0;
                            n_phase = PH_GROUP;
                        end else begin
                            n_pos = r_pos + 2'd1;
                        end
                    end
                    PH_GROUP, PH_PAIR, PH_AKM: begin
                        if (r_pos == SEL_LAST) begin
                            n_pos            = 2'd0;
                            n_shift          = 32'd0;
                            a_vld            = 1'b1;
                            a_res.suite_word = shift_new;
                            if (r_phase == PH_GROUP) begin
                                a_res.kind = KIND_GROUP;
                                n_phase    = PH_PCNT;
                            end else begin
                                a_res.kind = (r_phase == PH_PAIR) ? KIND_PAIR : KIND_AKM;
                                n_suites   = r_suites - 16'd1;
                                if (r_suites == 16'd1) begin
                                    n_phase = (r_phase == PH_PAIR) ? PH_ACNT : PH_SKIP;
                                end
                            end
                        end else begin
                            n_shift = shift_new;
                            n_pos   = r_pos + 2'd1;
                        end
                    end
                    PH_PCNT, PH_ACNT: begin
                        if (r_pos == 2'd0) begin
                            n_cnt_lo = b;
                            n_pos    = 2'd1;
                        end else begin
                            n_pos = 2'd0;
                            // pairwise list plus the AKM count, or the AKM list, must fit what is left
                            if ((r_phase == PH_PCNT &&
                                 ({cnt, 2'b00} + 18'd2) > {10'd0, el_dec}) ||
                                (r_phase == PH_ACNT && {cnt, 2'b00} > {10'd0, el_dec}))
                            begin
                                body_fail  = 1'b1;
                                a_vld      = 1'b1;
                                a_res.kind = KIND_ERROR;
                                n_stopped  = 1'b1;
                            end else begin
                                n_suites = cnt;
                                if (r_phase == PH_PCNT) begin
                                    n_phase = (cnt != 16'd0) ? PH_PAIR : PH_ACNT;
                                end else begin
                                    n_phase = (cnt != 16'd0) ? PH_AKM : PH_SKIP;
                                end
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_TYPE;
                    end
                endcase
                if (is_body && !body_fail && el_dec == 8'd0) begin
                    n_phase = PH_TYPE;
                end
            end

            // last byte of the frame: done, then back to reset state
            if (left == 16'd0) begin
                done      = 1'b1;
                n_phase   = PH_TYPE;
                n_type    = 8'd0;
                n_el      = 8'd0;
                n_pos     = 2'd0;
                n_suites  = 16'd0;
                n_cnt_lo  = 8'd0;
                n_shift   = 32'd0;
                n_ssid    = '0;
                n_stopped = 1'b0;
            end
        end
    end

    // order the results of this byte; the last one carries end_of_run
    always_comb begin
        done_res      = '0;
        done_res.kind = KIND_DONE;
        done_res.end_of_run = 1'b1;
        res1 = done_res;
        res0 = a_vld ? a_res : done_res;
        res0.end_of_run = !(a_vld && done);
        n_push = {2'd0, a_vld} + {2'd0, done};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TYPE;
            r_type    <= 8'd0;
            r_el      <= 8'd0;
            r_pos     <= 2'd0;
            r_suites  <= 16'd0;
            r_cnt_lo  <= 8'd0;
            r_shift   <= 32'd0;
            r_ssid    <= '0;
            r_stopped <= 1'b0;
            r_wr_ptr  <= 2'd0;
            r_rd_ptr  <= 2'd0;
            r_count   <= 3'd0;
        end else begin
            r_phase   <= n_phase;
            r_type    <= n_type;
            r_el      <= n_el;
            r_pos     <= n_pos;
            r_suites  <= n_suites;
            r_cnt_lo  <= n_cnt_lo;
            r_shift   <= n_shift;
            r_ssid    <= n_ssid;
            r_stopped <= n_stopped;
            r_wr_ptr  <= r_wr_ptr + n_push[1:0];
            r_rd_ptr  <= r_rd_ptr + {1'b0, pop};
            r_count   <= r_count + n_push - {2'd0, pop};
        end
    end

    // queue payload, no reset
    always_ff @(posedge i_clk) begin
        if (n_push != 3'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (n_push == 3'd2) begin
            r_fifo[r_wr_ptr + 2'd1] <= res1;
        end
    end

    assign i_in.ready        = (r_count <= 3'd2);
    assign o_out.valid       = (r_count != 3'd0);
    assign o_out.kind        = r_fifo[r_rd_ptr].kind;
    assign o_out.ssid_byte   = r_fifo[r_rd_ptr].ssid_byte;
    assign o_out.rate_whole  = r_fifo[r_rd_ptr].rate_whole;
    assign o_out.rate_tenths = r_fifo[r_rd_ptr].rate_tenths;
    assign o_out.basic_rate  = r_fifo[r_rd_ptr].basic_rate;
    assign o_out.suite_word  = r_fifo[r_rd_ptr].suite_word;
    assign o_out.end_of_run  = r_fifo[r_rd_ptr].end_of_run;

    // queue never overfills
    `WIP_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= 3'd4)
    // a last byte always leaves the parser in its reset state
    `WIP_ASSERT_NXT(a_frame_restart, i_clk, i_rst_n, acc && left == 16'd0,
                    r_phase == PH_TYPE && !r_stopped && r_ssid == '0)
    // SSID octet count bounded by the element limit
    `WIP_ASSERT_IMP(a_ssid_bound, i_clk, i_rst_n, 1'b1, r_ssid <= SSID_CNT_W'(SSID_MAX))
    // a pop with nothing pushed shrinks the queue by one
    `WIP_ASSERT_NXT(a_pop_only, i_clk, i_rst_n, pop && !acc,
                    r_count == $past(r_count) - 3'd1)

endmodule

/* dv/wifi_ie_parser_top_tb.sv */
// Self-checking testbench for the information element parser top level.
`timescale 1ns / 100ps

module wifi_ie_parser_top_tb;

    import wip_pkg::*;

    // Tracks the element walk byte by byte and holds the results still due from the parser.
    class ie_walk_tracker;
        localparam int SUITE_OCTETS = 4;

        logic [3:0]  phase;
        logic [7:0]  elem_type;
        logic [7:0]  elem_left;
        logic [7:0]  rsn_pos;
        logic [15:0] suites_left;
        logic [7:0]  cnt_lo;
        logic [31:0] sel_shift;
        logic [5:0]  ssid_count;
        bit          stopped;

        t_result     step_out[$];
        t_result     due_results[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            phase       = PH_TYPE;
            elem_type   = 8'd0;
            elem_left   = 8'd0;
            rsn_pos     = 8'd0;
            suites_left = 16'd0;
            cnt_lo      = 8'd0;
            sel_shift   = 32'd0;
            ssid_count  = 6'd0;
            stopped     = 1'b0;
        endfunction

        function void post(logic [2:0] kind, logic [7:0] sb, logic [5:0] whole,
                           logic [3:0] tenths, logic basic, logic [31:0] sw);
            t_result r;
            r.kind        = kind;
            r.ssid_byte   = sb;
            r.rate_whole  = whole;
            r.rate_tenths = tenths;
            r.basic_rate  = basic;
            r.suite_word  = sw;
            r.end_of_run  = 1'b0;
            step_out.push_back(r);
        endfunction

        function void flag_error();
            post(KIND_ERROR, 8'd0, 6'd0, 4'd0, 1'b0, 32'd0);
            stopped = 1'b1;
        endfunction

        function void decode_rate(input logic [6:0] code, output logic [5:0] whole,
                                  output logic [3:0] tenths);
            tenths = 4'd0;
            case (code)
                7'd2:    whole = 6'd1;
                7'd4:    whole = 6'd2;
                7'd11: begin
                    whole  = 6'd5;
                    tenths = 4'd5;
                end
                7'd12:   whole = 6'd6;
                7'd18:   whole = 6'd9;
                7'd22:   whole = 6'd11;
                7'd24:   whole = 6'd12;
                7'd36:   whole = 6'd18;
                7'd44:   whole = 6'd22;
                7'd48:   whole = 6'd24;
                7'd66:   whole = 6'd33;
                7'd72:   whole = 6'd36;
                7'd96:   whole = 6'd48;
                7'd108:  whole = 6'd54;
                default: whole = 6'd0;
            endcase
        endfunction

        // One octet inside an element body.
        function void walk_body(logic [7:0] b);
            logic [31:0] cnt;
            logic [5:0]  whole;
            logic [3:0]  tenths;
            elem_left = elem_left - 8'd1;
            case (phase)
                PH_SSID: begin
                    if (ssid_count < SSID_MAX) begin
                        post(KIND_SSID, b, 6'd0, 4'd0, 1'b0, 32'd0);
                        ssid_count = ssid_count + 6'd1;
                    end
                end
                PH_RATES: begin
                    decode_rate(b[6:0], whole, tenths);
                    post(KIND_RATE, 8'd0, whole, tenths, b[7], 32'd0);
                end
                PH_VER: begin
                    rsn_pos = rsn_pos + 8'd1;
                    if (rsn_pos >= 8'd2) begin
                        rsn_pos = 8'd0;
                        phase   = PH_GROUP;
                    end
                end
                PH_GROUP, PH_PAIR, PH_AKM: begin
                    sel_shift = {sel_shift[23:0], b};
                    rsn_pos   = rsn_pos + 8'd1;
                    if (rsn_pos >= SUITE_OCTETS) begin
                        rsn_pos = 8'd0;
                        if (phase == PH_GROUP) begin
                            post(KIND_GROUP, 8'd0, 6'd0, 4'd0, 1'b0, sel_shift);
                            phase = PH_PCNT;
                        end else begin
                            post((phase == PH_PAIR) ? KIND_PAIR : KIND_AKM,
                                 8'd0, 6'd0, 4'd0, 1'b0, sel_shift);
                            suites_left = suites_left - 16'd1;
                            if (suites_left == 16'd0)
                                phase = (phase == PH_PAIR) ? PH_ACNT : PH_SKIP;
                        end
                        sel_shift = 32'd0;
                    end
                end
                PH_PCNT, PH_ACNT: begin
                    if (rsn_pos == 8'd0) begin
                        cnt_lo  = b;
                        rsn_pos = 8'd1;
                    end else begin
                        rsn_pos = 8'd0;
                        cnt     = {16'd0, b, cnt_lo};
                        if (phase == PH_PCNT) begin
                            // pairwise list plus the AKM count must fit what is left
                            if (cnt * SUITE_OCTETS + 2 > {24'd0, elem_left}) begin
                                flag_error();
                                return;
                            end
                            suites_left = cnt[15:0];
                            phase       = (cnt != 0) ? PH_PAIR : PH_ACNT;
                        end else begin
                            if (cnt * SUITE_OCTETS > {24'd0, elem_left}) begin
                                flag_error();
                                return;
                            end
                            suites_left = cnt[15:0];
                            phase       = (cnt != 0) ? PH_AKM : PH_SKIP;
                        end
                    end
                end
                default: ;
            endcase
            if (elem_left == 8'd0)
                phase = PH_TYPE;
        endfunction

        // Called for every accepted input transaction.
        function void walk_byte(logic [7:0] b, logic [15:0] left);
            t_result last;
            step_out.delete();
            if (!stopped) begin
                if (phase == PH_TYPE) begin
                    elem_type = b;
                    if (left == 16'd0)
                        stopped = 1'b1;
                    else
                        phase = PH_LEN;
                end else if (phase == PH_LEN) begin
                    elem_left = b;
                    if ({8'd0, b} > left) begin
                        stopped = 1'b1;
                    end else if (elem_type == ELEM_ID_RSN && b < RSN_LEN_MIN) begin
                        flag_error();
                    end else begin
                        ssid_count = 6'd0;
                        rsn_pos    = 8'd0;
                        sel_shift  = 32'd0;
                        if (b == 8'd0)
                            phase = PH_TYPE;
                        else if (elem_type == ELEM_ID_SSID)
                            phase = PH_SSID;
                        else if (elem_type == ELEM_ID_RATES)
                            phase = PH_RATES;
                        else if (elem_type == ELEM_ID_RSN)
                            phase = PH_VER;
                        else
                            phase = PH_SKIP;
                    end
                end else if (phase <= PH_AKM) begin
                    walk_body(b);
                end else begin
                    phase = PH_TYPE;
                end
            end
            if (left == 16'd0) begin
                post(KIND_DONE, 8'd0, 6'd0, 4'd0, 1'b0, 32'd0);
                clear_walk();
            end
            if (step_out.size() > 0) begin
                last = step_out[step_out.size() - 1];
                last.end_of_run = 1'b1;
                step_out[step_out.size() - 1] = last;
            end
            foreach (step_out[i])
                due_results.push_back(step_out[i]);
        endfunction

        function void diff(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
                mismatches++;
            end
        endfunction

        // Called for every accepted output transaction.
        function void match_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual kind %0d word %0h",
                         $time, got.kind, got.suite_word);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            diff("kind",        {29'd0, want.kind},        {29'd0, got.kind});
            diff("ssid_byte",   {24'd0, want.ssid_byte},   {24'd0, got.ssid_byte});
            diff("rate_whole",  {26'd0, want.rate_whole},  {26'd0, got.rate_whole});
            diff("rate_tenths", {28'd0, want.rate_tenths}, {28'd0, got.rate_tenths});
            diff("basic_rate",  {31'd0, want.basic_rate},  {31'd0, got.basic_rate});
            diff("suite_word",  want.suite_word,           got.suite_word);
            diff("end_of_run",  {31'd0, want.end_of_run},  {31'd0, got.end_of_run});
        endfunction
    endclass

    localparam int RANDOM_BYTES = 1850;
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off to fill the result queue
    localparam int DRAIN_CYCLES = 10;     // settle time once nothing is due

    logic i_clk;
    logic i_rst_n;

    wip_in_if  byte_if ();
    wip_out_if result_if ();

    wifi_ie_parser_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (result_if)
    );

    ie_walk_tracker tracker = new();

    // idling knobs, written only by the stimulus process
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_requests = 0;

    // octets of the frame being built
    logic [7:0] frame_bytes[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit: far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: random stalls, plus the odd long hold-off counted here in cycles.
    initial begin
        int holds_served;
        int hold_left;
        holds_served    = 0;
        hold_left       = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Result monitor: every output transaction is checked against the oldest due result.
    initial begin
        t_result got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_if.valid && result_if.ready) begin
                got.kind        = result_if.kind;
                got.ssid_byte   = result_if.ssid_byte;
                got.rate_whole  = result_if.rate_whole;
                got.rate_tenths = result_if.rate_tenths;
                got.basic_rate  = result_if.basic_rate;
                got.suite_word  = result_if.suite_word;
                got.end_of_run  = result_if.end_of_run;
                tracker.match_result(got);
            end
        end
    end

    // Offers one byte; entered and left at a falling edge. Random idle cycles go first.
    task automatic send_byte(logic [7:0] b, logic [15:0] left);
        while ($urandom_range(99) < src_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_if.valid      <= 1'b1;
        byte_if.data_byte  <= b;
        byte_if.bytes_left <= left;
        do
            @(posedge i_clk);
        while (!byte_if.ready);
        tracker.walk_byte(b, left);
        @(negedge i_clk);
    endtask

    task automatic put(logic [7:0] b);
        frame_bytes.push_back(b);
    endtask

    // selector octets go out most significant first
    task automatic put_word(logic [31:0] w);
        put(w[31:24]);
        put(w[23:16]);
        put(w[15:8]);
        put(w[7:0]);
    endtask

    task automatic put_count(logic [15:0] c);
        put(c[7:0]);
        put(c[15:8]);
    endtask

    // Sends the first keep octets of the built frame. A consistent truncation counts
    // bytes_left down from the kept size; an early end counts down from the full size
    // and forces zero on the last octet sent, so the frame stops inside an element.
    task automatic send_frame(int keep, bit early_end);
        int total;
        total = frame_bytes.size();
        for (int i = 0; i < keep; i++) begin
            if (early_end)
                send_byte(frame_bytes[i], (i == keep - 1) ? 16'd0 : 16'(total - 1 - i));
            else
                send_byte(frame_bytes[i], 16'(keep - 1 - i));
        end
        frame_bytes.delete();
    endtask

    function automatic logic [31:0] pick_suite();
        if ($urandom_range(1) == 0)
            return {24'h000FAC, 8'($urandom_range(0, 13))};
        return $urandom();
    endfunction

    function automatic logic [6:0] pick_rate_code();
        case ($urandom_range(13))
            0:  return 7'd2;
            1:  return 7'd4;
            2:  return 7'd11;
            3:  return 7'd12;
            4:  return 7'd18;
            5:  return 7'd22;
            6:  return 7'd24;
            7:  return 7'd36;
            8:  return 7'd44;
            9:  return 7'd48;
            10: return 7'd66;
            11: return 7'd72;
            12: return 7'd96;
            default: return 7'd108;
        endcase
    endfunction

    task automatic add_ssid(int len);
        put(ELEM_ID_SSID);
        put(8'(len));
        repeat (len) put(8'($urandom_range(255)));
    endtask

    task automatic add_rates(int len);
        put(ELEM_ID_RATES);
        put(8'(len));
        repeat (len) begin
            if ($urandom_range(3) != 0)
                put({1'($urandom_range(1)), pick_rate_code()});
            else
                put(8'($urandom_range(255)));
        end
    endtask

    // flavour: 0 well formed, 1 random pairwise count, 2 random AKM count, 3 short element
    task automatic add_rsn(int pairs, int akms, int extra, int flavour);
        logic [15:0] pcnt;
        logic [15:0] acnt;
        int          len;
        put(ELEM_ID_RSN);
        if (flavour == 3) begin
            len = $urandom_range(0, RSN_LEN_MIN - 1);
            put(8'(len));
            repeat (len) put(8'($urandom_range(255)));
        end else begin
            pcnt = (flavour == 1) ? 16'($urandom_range(0, 65535)) : 16'(pairs);
            acnt = (flavour == 2) ? 16'($urandom_range(0, 65535)) : 16'(akms);
            len  = 2 + 4 + 2 + 4 * pairs + 2 + 4 * akms + extra;
            put(8'(len));
            put(8'd1);
            put(8'd0);
            put_word(pick_suite());
            put_count(pcnt);
            repeat (pairs) put_word(pick_suite());
            put_count(acnt);
            repeat (akms) put_word(pick_suite());
            repeat (extra) put(8'($urandom_range(255)));
        end
    endtask

    task automatic add_other();
        logic [7:0] t;
        int         len;
        t = 8'($urandom_range(255));
        if (t == ELEM_ID_SSID || t == ELEM_ID_RATES || t == ELEM_ID_RSN)
            t = 8'd221;
        len = $urandom_range(0, 20);
        put(t);
        put(8'(len));
        repeat (len) put(8'($urandom_range(255)));
    endtask

    task automatic add_random_element();
        int sel;
        sel = $urandom_range(99);
        if (sel < 25)
            add_ssid($urandom_range(0, 40));
        else if (sel < 45)
            add_rates($urandom_range(0, 10));
        else if (sel < 80)
            add_rsn($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 6),
                    ($urandom_range(99) < 70) ? 0 : $urandom_range(1, 3));
        else
            add_other();
    endtask

    task automatic directed_frames();
        // type octet is the last of the buffer
        put(8'hFF);
        send_frame(1, 1'b0);
        // largest bytes_left, empty element, then a bare type octet at the end
        send_byte(8'hFF, 16'hFFFF);
        send_byte(8'h00, 16'hFFFE);
        send_byte(8'h00, 16'h0000);
        // short SSID; the last body octet gives an SSID octet and done together
        put(ELEM_ID_SSID); put(8'd3); put(8'h00); put(8'hFF); put(8'h5A);
        send_frame(5, 1'b0);
        // length beyond the buffer
        put(ELEM_ID_RATES); put(8'd9); put(8'h82);
        send_frame(3, 1'b0);
        // rates: basic flags, 5.5, the corrected 36, an unknown code, 54
        put(ELEM_ID_RATES); put(8'd5);
        put(8'h82); put(8'h8B); put(8'd72); put(8'h7F); put(8'hEC);
        send_frame(7, 1'b0);
        // short RSN element on the last octet: error, then done
        put(ELEM_ID_RSN); put(8'd0);
        send_frame(2, 1'b0);
        // pairwise count far too large
        put(ELEM_ID_RSN); put(8'd14); put(8'd1); put(8'd0);
        put_word(32'h000FAC04); put_count(16'hFFFF);
        repeat (6) put(8'h00);
        send_frame(frame_bytes.size(), 1'b0);
        // AKM count larger than what is left
        put(ELEM_ID_RSN); put(8'd18); put(8'd1); put(8'd0);
        put_word(32'h000FAC04); put_count(16'd1); put_word(32'h000FAC04);
        put_count(16'd2); put_word(32'h000FAC02);
        send_frame(frame_bytes.size(), 1'b0);
        // well-formed RSN with trailing capability octets, a skipped vendor element,
        // then a frame that ends inside an SSID body
        put(ELEM_ID_RSN); put(8'd20); put(8'd1); put(8'd0);
        put_word(32'h000FAC04); put_count(16'd1); put_word(32'h000FAC02);
        put_count(16'd1); put_word(32'hFFFFFFFF); put(8'h0C); put(8'h00);
        put(8'd221); put(8'd2); put(8'hAA); put(8'h55);
        put(ELEM_ID_SSID); put(8'd5); put(8'h41); put(8'h42);
        send_frame(frame_bytes.size(), 1'b1);
    endtask

    // Stimulus: directed frames, then random frames under each idling phase.
    initial begin
        int src_pct[4];
        int sink_pct[4];
        int sent;
        int size;
        int keep;
        int pick;
        src_pct  = '{0, 51, 0, 15};
        sink_pct = '{0, 0, 51, 15};

        byte_if.valid      = 1'b0;
        byte_if.data_byte  = 8'd0;
        byte_if.bytes_left = 16'd0;
        i_rst_n            = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_frames();

        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = src_pct[p];
            sink_stall_pct = sink_pct[p];
            // back-pressure burst while the sender keeps offering bytes
            if (p == 0)
                hold_requests++;
            sent = 0;
            while (sent < RANDOM_BYTES / 4) begin
                if ($urandom_range(99) < 5) begin
                    // noise transaction, bytes_left anywhere in its range
                    send_byte(8'($urandom_range(255)), 16'($urandom_range(0, 65535)));
                end else begin
                    repeat ($urandom_range(1, 4)) add_random_element();
                    size = frame_bytes.size();
                    pick = $urandom_range(99);
                    if (pick < 80) begin
                        keep = size;
                        send_frame(keep, 1'b0);
                    end else begin
                        keep = $urandom_range(1, size);
                        send_frame(keep, pick >= 90);
                    end
                    sent += keep;
                end
            end
        end
        byte_if.valid <= 1'b0;

        // let every due result come out, then a short settle
        while (tracker.due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/wip_pkg.sv
rtl/core/wip_if.sv
rtl/core/wifi_ie_parser_top.sv
dv/wifi_ie_parser_top_tb.sv
